// ===== rtl/arlc_pkg.sv =====
// ----------------------------------------------------------------------------
// arlc_pkg
// Types, character codes and result string tables for the AT response line
// classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package arlc_pkg;

	typedef enum logic [1:0] {
		FR_START = 2'd0,
		FR_DATA  = 2'd1,
		FR_CR    = 2'd2
	} framing_t;

	typedef enum logic [1:0] {
		PH_BEFORE = 2'd0,
		PH_SIGN   = 2'd1,
		PH_DIGITS = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		KIND_INFO   = 3'd0,
		KIND_PROMPT = 3'd1,
		KIND_OK     = 3'd2,
		KIND_ERROR  = 3'd3,
		KIND_CME    = 3'd4,
		KIND_CMS    = 3'd5
	} kind_t;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam int NUM_PAT    = 9;
	localparam int PAT_PROMPT = 8;
	localparam int PAT_SLOTS  = 16;
	localparam int PREFIX_LEN = 11;

	localparam logic [15:0] CODE_SAT     = 16'd32768;
	localparam logic [15:0] CODE_POS_MAX = 16'd32767;

	localparam logic [7:0] PAT_TEXT [NUM_PAT][PAT_SLOTS] = '{
		'{"O", "K", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"E", "R", "R", "O", "R", 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"N", "O", " ", "C", "A", "R", "R", "I",
		  "E", "R", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"N", "O", " ", "D", "I", "A", "L", "T",
		  "O", "N", "E", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"B", "U", "S", "Y", 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"N", "O", " ", "A", "N", "S", "W", "E",
		  "R", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"+", "C", "M", "E", " ", "E", "R", "R",
		  "O", "R", ":", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"+", "C", "M", "S", " ", "E", "R", "R",
		  "O", "R", ":", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{">", " ", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	localparam logic [3:0] PAT_LEN [NUM_PAT] = '{
		4'd2, 4'd5, 4'd10, 4'd11, 4'd4, 4'd9, 4'd11, 4'd11, 4'd2
	};

	// Patterns that need only match the start of the line
	localparam logic [NUM_PAT-1:0] PAT_PREFIX = 9'b1_1100_0000;

	localparam kind_t PAT_KIND [NUM_PAT] = '{
		KIND_OK, KIND_ERROR, KIND_ERROR, KIND_ERROR, KIND_ERROR, KIND_ERROR,
		KIND_CME, KIND_CMS, KIND_PROMPT
	};

endpackage

`default_nettype wire

// ===== rtl/at_response_line_classifier.sv =====
// ----------------------------------------------------------------------------
// at_response_line_classifier
// Frames modem receive bytes into lines and classifies each completed line.
// ----------------------------------------------------------------------------
// One received byte is taken per clock cycle while the input is not held. A
// byte waits in an input register, where the framing, string matching and
// error number logic update the line state; a completed line is written to
// the output register when the byte that ends it leaves the input register,
// and the result is offered from there until it is transferred.
// Throughput is one byte per cycle for as long as the result side takes its
// transfers; the single output register is the only buffer, and a result
// that is not taken holds the input side once the input register is also
// occupied. Leading CR/LF bytes are skipped, lines end on LF or CRLF, "> "
// after CR is a prompt, and at most LINE_LIMIT-1 bytes of a line are kept,
// with the rest dropped and flagged.
`default_nettype none

module at_response_line_classifier #(
	parameter int LINE_LIMIT = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave side
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  wire logic        s_tuser,   // [0] abort_line
	// master side
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // [5:0] line_length, [21:6] err_num, zero pad
	output logic [3:0]       m_tuser    // [2:0] line_kind, [3] truncated
);

	localparam int LEN_W = $clog2(LINE_LIMIT);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_LIMIT - 1);
	localparam int NP = arlc_pkg::NUM_PAT;

	// input register
	logic            v_s1;
	logic [7:0]      byte_s1;
	logic            abort_s1;

	// line state
	arlc_pkg::framing_t fr_q;
	logic [LEN_W-1:0]   len_q;
	logic [NP-1:0]      alive_q;
	arlc_pkg::phase_t   ph_q;
	logic [15:0]        val_q;
	logic               neg_q;
	logic               ovf_q;

	// output register
	logic               m_valid_q;
	logic [5:0]         o_len_q;
	logic [15:0]        o_code_q;
	arlc_pkg::kind_t    o_kind_q;
	logic               o_trunc_q;

	logic adv_s1;
	logic do_store;
	logic do_finish;

	// after-store values
	logic [LEN_W-1:0]   st_len;
	logic [NP-1:0]      st_alive;
	arlc_pkg::phase_t   st_ph;
	logic [15:0]        st_val;
	logic               st_neg;
	logic               st_ovf;
	arlc_pkg::framing_t fr_next;

	logic [18:0]        val_mul;
	logic               is_digit;
	logic [3:0]         pidx;

	arlc_pkg::kind_t    fin_kind;
	logic               fin_found;
	logic [15:0]        fin_code;
	logic [16:0]        neg_code;

	assign adv_s1   = v_s1 && (!m_valid_q || m_tready);
	assign s_tready = !v_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata;
			abort_s1 <= s_tuser;
		end
	end

	// framing decisions
	always_comb begin
		do_store  = 1'b0;
		do_finish = 1'b0;
		fr_next   = fr_q;
		case (fr_q)
			arlc_pkg::FR_START: begin
				if (byte_s1 != arlc_pkg::CH_CR && byte_s1 != arlc_pkg::CH_LF) begin
					do_store = 1'b1;
					fr_next  = arlc_pkg::FR_DATA;
				end
			end
			arlc_pkg::FR_DATA: begin
				if (byte_s1 == arlc_pkg::CH_CR) begin
					fr_next = arlc_pkg::FR_CR;
				end else if (byte_s1 == arlc_pkg::CH_LF) begin
					do_finish = 1'b1;
				end else begin
					do_store = 1'b1;
				end
			end
			arlc_pkg::FR_CR: begin
				if (byte_s1 == arlc_pkg::CH_LF) begin
					do_finish = 1'b1;
				end else if (byte_s1 == arlc_pkg::CH_SPACE && len_q == LEN_W'(1)
						&& alive_q[arlc_pkg::PAT_PROMPT]) begin
					do_store  = 1'b1;
					do_finish = 1'b1;
				end else begin
					do_store = 1'b1;
					fr_next  = arlc_pkg::FR_DATA;
				end
			end
			default: begin
				fr_next = arlc_pkg::FR_START;
			end
		endcase
	end

	// store one byte: pattern flags, error number, length
	assign pidx     = len_q[3:0];
	assign is_digit = (byte_s1 >= arlc_pkg::CH_ZERO) && (byte_s1 <= arlc_pkg::CH_NINE);
	assign val_mul  = {val_q, 3'b000} + {2'b00, val_q, 1'b0}
	                  + {11'd0, byte_s1 - arlc_pkg::CH_ZERO};

	always_comb begin
		st_len   = len_q;
		st_alive = alive_q;
		st_ph    = ph_q;
		st_val   = val_q;
		st_neg   = neg_q;
		st_ovf   = ovf_q;
		if (do_store) begin
			if (len_q >= LEN_MAX) begin
				st_ovf = 1'b1;
			end else begin
				for (int i = 0; i < NP; i++) begin
					if (len_q < LEN_W'(arlc_pkg::PAT_LEN[i])) begin
						if (arlc_pkg::PAT_TEXT[i][pidx] != byte_s1) begin
							st_alive[i] = 1'b0;
						end
					end else if (!arlc_pkg::PAT_PREFIX[i]) begin
						st_alive[i] = 1'b0;
					end
				end
				if (len_q >= LEN_W'(arlc_pkg::PREFIX_LEN) && ph_q != arlc_pkg::PH_DONE) begin
					if (is_digit) begin
						st_ph  = arlc_pkg::PH_DIGITS;
						st_val = (val_mul > 19'(arlc_pkg::CODE_SAT)) ?
						         arlc_pkg::CODE_SAT : val_mul[15:0];
					end else if (ph_q == arlc_pkg::PH_BEFORE
							&& byte_s1 == arlc_pkg::CH_SPACE) begin
						st_ph = arlc_pkg::PH_BEFORE;
					end else if (ph_q == arlc_pkg::PH_BEFORE
							&& (byte_s1 == arlc_pkg::CH_PLUS
							|| byte_s1 == arlc_pkg::CH_MINUS)) begin
						st_neg = (byte_s1 == arlc_pkg::CH_MINUS);
						st_ph  = arlc_pkg::PH_SIGN;
					end else begin
						st_ph = arlc_pkg::PH_DONE;
					end
				end
				st_len = len_q + LEN_W'(1);
			end
		end
	end

	// classify the line as it stands after the store
	always_comb begin
		fin_kind  = arlc_pkg::KIND_INFO;
		fin_found = 1'b0;
		if (st_alive[arlc_pkg::PAT_PROMPT] && st_len >= LEN_W'(2)) begin
			fin_kind = arlc_pkg::KIND_PROMPT;
		end else begin
			for (int i = 0; i < NP - 1; i++) begin
				if (!fin_found && st_alive[i]
						&& (arlc_pkg::PAT_PREFIX[i] ?
						    (st_len >= LEN_W'(arlc_pkg::PAT_LEN[i])) :
						    (st_len == LEN_W'(arlc_pkg::PAT_LEN[i])))) begin
					fin_found = 1'b1;
					fin_kind  = arlc_pkg::PAT_KIND[i];
				end
			end
		end
	end

	assign neg_code = 17'h10000 - {1'b0, st_val};

	always_comb begin
		fin_code = 16'd0;
		if (fin_kind == arlc_pkg::KIND_CME || fin_kind == arlc_pkg::KIND_CMS) begin
			if (st_neg) begin
				fin_code = neg_code[15:0];
			end else begin
				fin_code = (st_val > arlc_pkg::CODE_POS_MAX) ?
				           arlc_pkg::CODE_POS_MAX : st_val;
			end
		end
	end

	// line state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_q    <= arlc_pkg::FR_START;
			len_q   <= '0;
			alive_q <= '1;
			ph_q    <= arlc_pkg::PH_BEFORE;
			val_q   <= '0;
			neg_q   <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (adv_s1) begin
			if (abort_s1 || do_finish) begin
				fr_q    <= arlc_pkg::FR_START;
				len_q   <= '0;
				alive_q <= '1;
				ph_q    <= arlc_pkg::PH_BEFORE;
				val_q   <= '0;
				neg_q   <= 1'b0;
				ovf_q   <= 1'b0;
			end else begin
				fr_q    <= fr_next;
				len_q   <= st_len;
				alive_q <= st_alive;
				ph_q    <= st_ph;
				val_q   <= st_val;
				neg_q   <= st_neg;
				ovf_q   <= st_ovf;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv_s1 && !abort_s1 && do_finish) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && !abort_s1 && do_finish) begin
			o_kind_q  <= fin_kind;
			o_len_q   <= 6'(st_len);
			o_code_q  <= fin_code;
			o_trunc_q <= st_ovf;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, o_code_q, o_len_q};
	assign m_tuser  = {o_trunc_q, o_kind_q};

	// checks
	property p_start_empty;
		@(posedge clk) disable iff (!arst_n)
		fr_q == arlc_pkg::FR_START |-> (len_q == '0 && !ovf_q && alive_q == '1);
	endproperty
	a_start_empty: assert property (p_start_empty)
		else $error("line state not clear in start");

	property p_result_hold;
		@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser);
	endproperty
	a_result_hold: assert property (p_result_hold)
		else $error("result changed while waiting for its transfer");

	property p_code_kind;
		@(posedge clk) disable iff (!arst_n)
		m_valid_q && o_kind_q != arlc_pkg::KIND_CME && o_kind_q != arlc_pkg::KIND_CMS
			|-> o_code_q == 16'd0;
	endproperty
	a_code_kind: assert property (p_code_kind)
		else $error("error number on a line without cme/cms prefix");

	property p_trunc_full;
		@(posedge clk) disable iff (!arst_n)
		m_valid_q && o_trunc_q |-> o_len_q == 6'(LEN_MAX);
	endproperty
	a_trunc_full: assert property (p_trunc_full)
		else $error("truncated line not at full length");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the AT response line classifier.
// ----------------------------------------------------------------------------
// Bytes are queued by the stimulus process and offered by a clocked driver.
// Every byte the block accepts also goes through a line framer and
// classifier in this file. Each completed line leaves an expected result
// behind, and the monitor compares each result transfer against the oldest
// one. The stimulus is mostly well-formed modem responses (final result
// words, CME/CMS reports with awkward numbers, prompts, free text and
// over-long lines) mixed with raw noise, stray CRs and aborts. Idling on
// both sides changes between phases, and one long receiver hold-off forces
// the block to stall its input.
module tb;

	localparam int LINE_LIMIT   = 64;
	localparam int NUM_PATS     = 9;
	localparam int PROMPT_PAT   = 8;
	localparam logic [8:0] PREFIX_PATS = 9'b1_1100_0000;
	localparam int PHASE_BYTES  = 630;
	localparam int HOLD_AT      = 1500;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct packed {
		logic       abort;
		logic [7:0] rx;
	} rx_item_t;

	typedef struct packed {
		arlc_pkg::kind_t kind;
		logic [5:0]      len;
		logic [15:0]     code;
		logic            trunc;
	} line_result_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;   // [7:0] rx_byte
	logic        s_tuser   = 1'b0; // [0] abort_line
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;          // [5:0] line_length, [21:6] err_num, zero pad
	logic [3:0]  m_tuser;          // [2:0] line_kind, [3] truncated

	rx_item_t     rx_items[$];
	line_result_t expected_lines[$];

	int sender_idle_pct   = 0;
	int receiver_idle_pct = 0;
	int stimulus_bytes    = 0;
	int bytes_taken       = 0;
	int aborts_seen       = 0;
	int lines_checked     = 0;
	int lines_truncated   = 0;
	int mismatches        = 0;
	int cycles            = 0;
	int lines_of_kind[6];

	// Line state of the local classifier
	arlc_pkg::framing_t fr_state;
	int unsigned        stored_len;
	logic [8:0]         still_matching;
	arlc_pkg::phase_t   num_phase;
	int unsigned        num_mag;
	bit                 num_neg;
	bit                 line_overflow;

	at_response_line_classifier #(.LINE_LIMIT(LINE_LIMIT)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	function automatic string pattern_text(int p);
		case (p)
			0: return "OK";
			1: return "ERROR";
			2: return "NO CARRIER";
			3: return "NO DIALTONE";
			4: return "BUSY";
			5: return "NO ANSWER";
			6: return "+CME ERROR:";
			7: return "+CMS ERROR:";
			default: return "> ";
		endcase
	endfunction

	function automatic arlc_pkg::kind_t pattern_kind(int p);
		case (p)
			0: return arlc_pkg::KIND_OK;
			6: return arlc_pkg::KIND_CME;
			7: return arlc_pkg::KIND_CMS;
			8: return arlc_pkg::KIND_PROMPT;
			default: return arlc_pkg::KIND_ERROR;
		endcase
	endfunction

	function automatic void clear_line_state();
		fr_state       = arlc_pkg::FR_START;
		stored_len     = 0;
		still_matching = '1;
		num_phase      = arlc_pkg::PH_BEFORE;
		num_mag        = 0;
		num_neg        = 1'b0;
		line_overflow  = 1'b0;
	endfunction

	function automatic void feed_error_number(logic [7:0] b);
		if (num_phase != arlc_pkg::PH_DONE) begin
			if (b >= arlc_pkg::CH_ZERO && b <= arlc_pkg::CH_NINE) begin
				num_phase = arlc_pkg::PH_DIGITS;
				num_mag   = num_mag * 10 + (b - arlc_pkg::CH_ZERO);
				if (num_mag > 32768)
					num_mag = 32768;
			end else if (num_phase == arlc_pkg::PH_BEFORE && b == arlc_pkg::CH_SPACE) begin
				// skip leading space
			end else if (num_phase == arlc_pkg::PH_BEFORE
			             && (b == arlc_pkg::CH_PLUS || b == arlc_pkg::CH_MINUS)) begin
				num_neg   = (b == arlc_pkg::CH_MINUS);
				num_phase = arlc_pkg::PH_SIGN;
			end else begin
				num_phase = arlc_pkg::PH_DONE;
			end
		end
	endfunction

	function automatic void store_line_byte(logic [7:0] b);
		string txt;
		if (stored_len >= LINE_LIMIT - 1) begin
			line_overflow = 1'b1;
		end else begin
			for (int p = 0; p < NUM_PATS; p++) begin
				txt = pattern_text(p);
				if (still_matching[p]) begin
					if (stored_len < txt.len()) begin
						if (txt[stored_len] != b)
							still_matching[p] = 1'b0;
					end else if (!PREFIX_PATS[p]) begin
						still_matching[p] = 1'b0;
					end
				end
			end
			if (stored_len >= arlc_pkg::PREFIX_LEN)
				feed_error_number(b);
			stored_len++;
		end
	endfunction

	function automatic void close_line();
		line_result_t r;
		string txt;
		int sel;
		sel = -1;
		if (still_matching[PROMPT_PAT] && stored_len >= 2) begin
			sel = PROMPT_PAT;
		end else begin
			for (int p = 0; p < PROMPT_PAT; p++) begin
				txt = pattern_text(p);
				if (sel < 0 && still_matching[p] &&
				    (PREFIX_PATS[p] ? stored_len >= txt.len() : stored_len == txt.len()))
					sel = p;
			end
		end
		r.kind  = (sel >= 0) ? pattern_kind(sel) : arlc_pkg::KIND_INFO;
		r.len   = 6'(stored_len);
		r.trunc = line_overflow;
		r.code  = '0;
		if (r.kind == arlc_pkg::KIND_CME || r.kind == arlc_pkg::KIND_CMS) begin
			if (num_neg)
				r.code = 16'(32'h10000 - num_mag);
			else
				r.code = (num_mag > 32767) ? arlc_pkg::CODE_POS_MAX : 16'(num_mag);
		end
		expected_lines.push_back(r);
		clear_line_state();
	endfunction

	function automatic void frame_and_classify(logic [7:0] b, logic abort);
		if (abort) begin
			aborts_seen++;
			clear_line_state();
		end else begin
			case (fr_state)
				arlc_pkg::FR_START: begin
					if (b != arlc_pkg::CH_CR && b != arlc_pkg::CH_LF) begin
						clear_line_state();
						store_line_byte(b);
						fr_state = arlc_pkg::FR_DATA;
					end
				end
				arlc_pkg::FR_DATA: begin
					if (b == arlc_pkg::CH_CR)
						fr_state = arlc_pkg::FR_CR;
					else if (b == arlc_pkg::CH_LF)
						close_line();
					else
						store_line_byte(b);
				end
				arlc_pkg::FR_CR: begin
					if (b == arlc_pkg::CH_LF) begin
						close_line();
					end else if (b == arlc_pkg::CH_SPACE && stored_len == 1
					             && still_matching[PROMPT_PAT]) begin
						store_line_byte(b);
						close_line();
					end else begin
						// the CR itself is not kept
						store_line_byte(b);
						fr_state = arlc_pkg::FR_DATA;
					end
				end
				default: clear_line_state();
			endcase
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus building
	// ------------------------------------------------------------------
	function automatic void add_byte(logic [7:0] b);
		rx_item_t it;
		it.abort = 1'b0;
		it.rx    = b;
		rx_items.push_back(it);
		stimulus_bytes++;
	endfunction

	function automatic void add_abort();
		rx_item_t it;
		it.abort = 1'b1;
		it.rx    = 8'($urandom_range(0, 255));
		rx_items.push_back(it);
		stimulus_bytes++;
	endfunction

	function automatic logic [7:0] printable();
		return 8'($urandom_range(32, 126));
	endfunction

	// mode 0 plain, 1 last char dropped, 2 one char appended, 3 one char replaced
	function automatic void add_word(string s, int mode);
		int k;
		k = $urandom_range(0, s.len() - 1);
		for (int i = 0; i < s.len(); i++) begin
			if (mode == 1 && i == s.len() - 1)
				break;
			add_byte((mode == 3 && i == k) ? printable() : s[i]);
		end
		if (mode == 2)
			add_byte(printable());
	endfunction

	function automatic void add_line_end();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				add_byte(arlc_pkg::CH_CR);
				add_byte(arlc_pkg::CH_LF);
			end
			6, 7: add_byte(arlc_pkg::CH_LF);
			8: begin
				// stray CR followed by a kept byte
				add_byte(arlc_pkg::CH_CR);
				add_byte(printable());
				add_byte(arlc_pkg::CH_CR);
				add_byte(arlc_pkg::CH_LF);
			end
			default: begin
				add_byte(arlc_pkg::CH_CR);
				add_byte(arlc_pkg::CH_CR);
				add_byte(arlc_pkg::CH_LF);
			end
		endcase
	endfunction

	function automatic void add_error_report();
		int n;
		add_word($urandom_range(0, 1) ? "+CME ERROR:" : "+CMS ERROR:",
		         ($urandom_range(0, 9) == 0) ? 3 : 0);
		repeat ($urandom_range(0, 2)) add_byte(arlc_pkg::CH_SPACE);
		case ($urandom_range(0, 2))
			1: add_byte(arlc_pkg::CH_PLUS);
			2: add_byte(arlc_pkg::CH_MINUS);
			default: ;
		endcase
		if ($urandom_range(0, 4) == 0) begin
			case ($urandom_range(0, 5))
				0: add_word("0", 0);
				1: add_word("32767", 0);
				2: add_word("32768", 0);
				3: add_word("32769", 0);
				4: add_word("99999", 0);
				default: add_word("0000065535", 0);
			endcase
		end else begin
			n = $urandom_range(0, 7);
			repeat (n) add_byte(arlc_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
		end
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) add_byte(printable());
	endfunction

	function automatic void add_random_line();
		int form;
		int n;
		repeat ($urandom_range(0, 2))
			add_byte($urandom_range(0, 1) ? arlc_pkg::CH_CR : arlc_pkg::CH_LF);
		form = $urandom_range(0, 19);
		if (form < 6) begin
			add_word(pattern_text($urandom_range(0, 5)),
			         ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 3));
		end else if (form < 10) begin
			add_error_report();
		end else if (form < 12) begin
			// prompt forms close themselves
			add_byte(">");
			case ($urandom_range(0, 3))
				0: begin
					add_byte(arlc_pkg::CH_CR);
					add_byte(arlc_pkg::CH_SPACE);
				end
				1: begin
					add_byte(arlc_pkg::CH_SPACE);
					repeat ($urandom_range(0, 5)) add_byte(printable());
					add_line_end();
				end
				2: begin
					add_byte(arlc_pkg::CH_CR);
					add_byte(printable());
					add_byte(arlc_pkg::CH_LF);
				end
				default: add_line_end();
			endcase
			return;
		end else if (form < 18) begin
			n = ($urandom_range(0, 11) == 0) ? $urandom_range(55, 90) : $urandom_range(1, 20);
			repeat (n) begin
				if ($urandom_range(0, 15) == 0)
					add_byte(arlc_pkg::CH_CR);
				add_byte(printable());
			end
		end else begin
			repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(0, 255)));
		end
		if ($urandom_range(0, 24) == 0)
			add_abort();
		add_line_end();
	endfunction

	function automatic void add_directed();
		add_byte(arlc_pkg::CH_CR);
		add_byte(arlc_pkg::CH_LF);
		add_word("OK", 0);
		add_byte(arlc_pkg::CH_CR);
		add_byte(arlc_pkg::CH_LF);
		add_byte(">");
		add_byte(arlc_pkg::CH_CR);
		add_byte(arlc_pkg::CH_SPACE);
		add_byte("Z");
		add_abort();
		add_word("+CMS ERROR:-32769", 0);
		add_byte(arlc_pkg::CH_LF);
	endfunction

	// ------------------------------------------------------------------
	// Clock, driver, receiver, monitor
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin : driver
		rx_item_t next_item;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				frame_and_classify(s_tdata, s_tuser);
				bytes_taken <= bytes_taken + 1;
			end
			if (!s_tvalid || s_tready) begin
				if (rx_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
					next_item = rx_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= next_item.rx;
					s_tuser  <= next_item.abort;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : receiver
		int hold_left;
		bit hold_started;
		if (!arst_n) begin
			m_tready     <= 1'b0;
			hold_left    = 0;
			hold_started = 1'b0;
		end else if (!hold_started && bytes_taken >= HOLD_AT) begin
			// long hold-off while the sender keeps offering
			hold_started = 1'b1;
			hold_left    = HOLD_CYCLES;
			m_tready     <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH at line %0d: %s got %0d want %0d", lines_checked, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin : monitor
		line_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_lines.size() == 0) begin
				report_mismatch("result with no line pending, kind", m_tuser[2:0], -1);
			end else begin
				want = expected_lines.pop_front();
				if (m_tuser[2:0] != want.kind)
					report_mismatch("line_kind", m_tuser[2:0], want.kind);
				if (m_tdata[5:0] != want.len)
					report_mismatch("line_length", m_tdata[5:0], want.len);
				if (m_tdata[21:6] != want.code)
					report_mismatch("err_num", $signed(m_tdata[21:6]), $signed(want.code));
				if (m_tuser[3] != want.trunc)
					report_mismatch("truncated", m_tuser[3], want.trunc);
				if (m_tdata[23:22] != 2'b00)
					report_mismatch("tdata pad", m_tdata[23:22], 0);
				if (want.kind <= arlc_pkg::KIND_CMS)
					lines_of_kind[want.kind]++;
				if (want.trunc)
					lines_truncated++;
			end
			lines_checked++;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d lines still pending",
			         cycles, expected_lines.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence of the run
	// ------------------------------------------------------------------
	initial begin
		int goal;
		clear_line_state();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					sender_idle_pct   = 25;
					receiver_idle_pct = 77;
					add_directed();
				end
				1: begin
					sender_idle_pct   = 77;
					receiver_idle_pct = 25;
				end
				default: begin
					sender_idle_pct   = 0;
					receiver_idle_pct = 0;
				end
			endcase
			goal = stimulus_bytes + PHASE_BYTES;
			while (stimulus_bytes < goal)
				add_random_line();
			while (rx_items.size() != 0 || s_tvalid)
				@(negedge clk);
		end
		while (expected_lines.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
		$display("Run covered %0d bytes (%0d aborts) and %0d lines, %0d of them truncated",
		         bytes_taken, aborts_seen, lines_checked, lines_truncated);
		$display("Lines by kind: info %0d prompt %0d ok %0d error %0d cme %0d cms %0d",
		         lines_of_kind[0], lines_of_kind[1], lines_of_kind[2],
		         lines_of_kind[3], lines_of_kind[4], lines_of_kind[5]);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
